// File: sv/kvt_pkg.sv
// Shared types, constants and command/status bundles of the key/value text tokenizer.
package kvt_pkg;

    localparam int PENDING_MAX = 16;
    localparam int HOLD_AW     = (PENDING_MAX > 1) ? $clog2(PENDING_MAX) : 1;
    localparam int HOLD_CW     = $clog2(PENDING_MAX + 1);
    localparam int MAX_TOKENS  = 3;
    localparam int TQ_CW       = $clog2(MAX_TOKENS + 1);

    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_SHIFT = 8'h20;

    typedef enum logic [2:0] {
        PH_BETWEEN,
        PH_MINUS,
        PH_COMMENT,
        PH_KEY,
        PH_AFTER_KEY,
        PH_BEFORE_VALUE,
        PH_VALUE,
        PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_FLUSH,
        SQ_TOKENS
    } seq_t;

    typedef enum logic [2:0] {
        KIND_KEY       = 3'd0,
        KIND_VALUE     = 3'd1,
        KIND_PAIR_END  = 3'd2,
        KIND_NO_EQUALS = 3'd3,
        KIND_TEXT_END  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        CSEL_ZERO,
        CSEL_MINUS,
        CSEL_KEY,
        CSEL_VALUE
    } char_sel_t;

    typedef struct packed {
        kind_t     kind;
        char_sel_t csel;
        logic      ovf;
    } tok_t;

    typedef struct packed {
        logic is_zero;
        logic is_ws;
        logic is_equals;
        logic is_newline;
        logic is_semi;
        logic is_minus;
    } byte_class_t;

    typedef struct packed {
        byte_class_t cls;
        logic        held_empty;
        logic        held_full;
        logic        ovf_seen;
        logic        flush_last;
        logic        tok_last;
        logic        tok_none;
        logic        out_free;
    } dp_status_t;

    typedef struct packed {
        logic                        accept;
        logic                        hold_push;
        logic                        hold_clear;
        logic                        ovf_next;
        logic                        flush_adv;
        logic                        tok_adv;
        logic [TQ_CW-1:0]            tok_cnt;
        tok_t [MAX_TOKENS-1:0]       toks;
    } dp_cmd_t;

endpackage

// File: sv/key_value_text_tokenizer_top.sv
// Top level of the key/value text tokenizer: controller plus datapath.
//
// Reads a property text one byte per request and emits the key=value pairs
// as a stream of tokens: key characters (A-Z lowercased), value characters,
// pair end, missing-equals error and text end. Whitespace between pairs is
// skipped, "--" at a key start opens a comment to the line end, and a value
// ends at newline, ';' (which then begins the next key) or end of text.
// Trailing whitespace inside a value is held in a 16-entry hold RAM: it is
// dropped at the value end and replayed when a later value byte arrives; a
// run longer than the store is replayed early and the pair end is flagged.
// s_tlast marks the final byte; a zero byte also ends the text, and bytes
// after it are dropped until the final byte. Bytes that cause no result
// stream at one per cycle; a byte that causes results holds off the next
// byte until all of them are issued, one result per cycle into the output
// register while it is free (m_tready low stalls it). Replayed whitespace
// comes from the hold RAM one character per cycle on the same terms. A new
// request is taken while the last result of the previous one still waits
// in the output register. The hold RAM needs no clearing after reset.
module key_value_text_tokenizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic [3:0] m_tuser,   // [2:0] token_kind, [3] trim_overflow
    output logic       m_tlast    // run_last
);

    kvt_pkg::dp_cmd_t    cmd;
    kvt_pkg::dp_status_t status;

    // Sequence each request: plan its results, replay held whitespace,
    // then issue the queued tokens.
    kvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the byte, the whitespace store and the output register.
    kvt_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sv/kvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/kvt_dp.sv
// Datapath: byte classing, whitespace hold store, token queue and output register.
module kvt_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          s_tdata,
    input  kvt_pkg::dp_cmd_t    cmd,
    output kvt_pkg::dp_status_t status,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic [3:0]          m_tuser,
    output logic                m_tlast
);

    logic [7:0]                   byte_reg;
    logic [kvt_pkg::HOLD_CW-1:0]  held_count_reg, held_count_next;
    logic                         ovf_reg;
    logic [kvt_pkg::HOLD_CW-1:0]  flush_idx_reg, flush_idx_next;
    kvt_pkg::tok_t [kvt_pkg::MAX_TOKENS-1:0] tq_reg;
    logic [kvt_pkg::TQ_CW-1:0]    tq_cnt_reg;
    logic [kvt_pkg::TQ_CW-1:0]    tq_idx_reg;

    logic                         out_valid_reg, out_valid_next;
    kvt_pkg::kind_t               out_kind_reg;
    logic [7:0]                   out_char_reg;
    logic                         out_ovf_reg;
    logic                         out_last_reg;

    logic                         ram_we;
    logic [kvt_pkg::HOLD_AW-1:0]  ram_waddr;
    logic [7:0]                   ram_wdata;
    logic [7:0]                   ram_rdata;

    kvt_pkg::tok_t                cur_tok;
    logic [7:0]                   key_char;
    logic [7:0]                   tok_char;
    logic                         out_free;

    assign out_free = !out_valid_reg || m_tready;

    // classify the offered byte and report store, queue and output state
    always_comb begin
        status.cls.is_zero    = (s_tdata == 8'h00);
        status.cls.is_ws      = (s_tdata == kvt_pkg::CH_SPACE) ||
                                (s_tdata inside {[kvt_pkg::CH_TAB:kvt_pkg::CH_CR]});
        status.cls.is_equals  = (s_tdata == kvt_pkg::CH_EQUALS);
        status.cls.is_newline = (s_tdata == kvt_pkg::CH_NEWLINE);
        status.cls.is_semi    = (s_tdata == kvt_pkg::CH_SEMI);
        status.cls.is_minus   = (s_tdata == kvt_pkg::CH_MINUS);
        status.held_empty     = (held_count_reg == '0);
        status.held_full      = (held_count_reg == kvt_pkg::HOLD_CW'(kvt_pkg::PENDING_MAX));
        status.ovf_seen       = ovf_reg;
        status.flush_last     = (kvt_pkg::HOLD_CW'(flush_idx_reg + 1'b1) == held_count_reg);
        status.tok_last       = (kvt_pkg::TQ_CW'(tq_idx_reg + 1'b1) == tq_cnt_reg);
        status.tok_none       = (tq_cnt_reg == '0);
        status.out_free       = out_free;
    end

    // hold store
    assign ram_we    = cmd.hold_push;
    assign ram_waddr = cmd.hold_clear ? '0 : held_count_reg[kvt_pkg::HOLD_AW-1:0];
    assign ram_wdata = cmd.accept ? s_tdata : byte_reg;

    always_comb begin
        if (cmd.accept) begin
            flush_idx_next = '0;
        end else if (cmd.flush_adv) begin
            flush_idx_next = kvt_pkg::HOLD_CW'(flush_idx_reg + 1'b1);
        end else begin
            flush_idx_next = flush_idx_reg;
        end
    end

    kvt_ram #(
        .WIDTH (8),
        .DEPTH (kvt_pkg::PENDING_MAX)
    ) u_hold_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (flush_idx_next[kvt_pkg::HOLD_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (cmd.hold_clear) begin
            held_count_next = cmd.hold_push ? kvt_pkg::HOLD_CW'(1) : '0;
        end else if (cmd.hold_push) begin
            held_count_next = kvt_pkg::HOLD_CW'(held_count_reg + 1'b1);
        end else begin
            held_count_next = held_count_reg;
        end
    end

    // token character selection
    assign cur_tok  = tq_reg[tq_idx_reg];
    assign key_char = (byte_reg inside {[kvt_pkg::CH_UPPER_A:kvt_pkg::CH_UPPER_Z]}) ?
                      8'(byte_reg + kvt_pkg::CASE_SHIFT) : byte_reg;

    always_comb begin
        case (cur_tok.csel)
            kvt_pkg::CSEL_MINUS: tok_char = kvt_pkg::CH_MINUS;
            kvt_pkg::CSEL_KEY:   tok_char = key_char;
            kvt_pkg::CSEL_VALUE: tok_char = byte_reg;
            default:             tok_char = 8'h00;
        endcase
    end

    always_comb begin
        if (cmd.flush_adv || cmd.tok_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            flush_idx_reg  <= '0;
            tq_cnt_reg     <= '0;
            tq_idx_reg     <= '0;
        end else begin
            held_count_reg <= held_count_next;
            out_valid_reg  <= out_valid_next;
            flush_idx_reg  <= flush_idx_next;
            if (cmd.accept) begin
                ovf_reg    <= cmd.ovf_next;
                tq_cnt_reg <= cmd.tok_cnt;
                tq_idx_reg <= '0;
            end else if (cmd.tok_adv) begin
                tq_idx_reg <= kvt_pkg::TQ_CW'(tq_idx_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_tdata;
            tq_reg   <= cmd.toks;
        end
        if (cmd.flush_adv) begin
            out_kind_reg <= kvt_pkg::KIND_VALUE;
            out_char_reg <= ram_rdata;
            out_ovf_reg  <= 1'b0;
            out_last_reg <= status.flush_last && (tq_cnt_reg == '0);
        end else if (cmd.tok_adv) begin
            out_kind_reg <= cur_tok.kind;
            out_char_reg <= tok_char;
            out_ovf_reg  <= cur_tok.ovf;
            out_last_reg <= status.tok_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = {out_ovf_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: sv/kvt_ctrl.sv
// Controller: parse phase, per-byte result plan and result sequencer.
module kvt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    input  kvt_pkg::dp_status_t status,
    output kvt_pkg::dp_cmd_t    cmd
);

    kvt_pkg::phase_t phase_reg, phase_next;
    kvt_pkg::seq_t   seq_reg, seq_next;
    logic            push_late_reg, push_late_next;

    kvt_pkg::phase_t                         plan_phase;
    kvt_pkg::tok_t [kvt_pkg::MAX_TOKENS-1:0] plan_toks;
    logic [kvt_pkg::TQ_CW-1:0]               plan_cnt;
    logic                                    plan_flush;
    logic                                    plan_push;
    logic                                    plan_push_late;
    logic                                    plan_clear;
    logic                                    plan_ovf;

    logic accept;
    logic flush_end;

    assign accept    = (seq_reg == kvt_pkg::SQ_IDLE) && s_tvalid;
    assign flush_end = (seq_reg == kvt_pkg::SQ_FLUSH) && status.out_free && status.flush_last;

    // work out every result the offered byte causes
    always_comb begin
        kvt_pkg::phase_t ph;
        kvt_pkg::phase_t te_ph;
        logic            do_start;
        logic            do_key;
        logic            do_end;

        plan_toks      = '0;
        plan_cnt       = '0;
        plan_flush     = 1'b0;
        plan_push      = 1'b0;
        plan_push_late = 1'b0;
        plan_clear     = 1'b0;
        plan_ovf       = status.ovf_seen;
        ph             = phase_reg;
        do_start       = 1'b0;
        do_key         = 1'b0;
        do_end         = 1'b0;

        if (!status.cls.is_zero) begin
            case (phase_reg)
                kvt_pkg::PH_BETWEEN: begin
                    do_start = 1'b1;
                end
                kvt_pkg::PH_MINUS: begin
                    if (status.cls.is_minus) begin
                        ph = kvt_pkg::PH_COMMENT;
                    end else begin
                        plan_toks[plan_cnt] = '{kvt_pkg::KIND_KEY, kvt_pkg::CSEL_MINUS, 1'b0};
                        plan_cnt = plan_cnt + 1'b1;
                        ph       = kvt_pkg::PH_KEY;
                        do_key   = 1'b1;
                    end
                end
                kvt_pkg::PH_COMMENT: begin
                    if (status.cls.is_newline) begin
                        ph = kvt_pkg::PH_BETWEEN;
                    end
                end
                kvt_pkg::PH_KEY: begin
                    do_key = 1'b1;
                end
                kvt_pkg::PH_AFTER_KEY: begin
                    if (status.cls.is_equals) begin
                        ph = kvt_pkg::PH_BEFORE_VALUE;
                    end else if (!status.cls.is_ws) begin
                        plan_toks[plan_cnt] = '{kvt_pkg::KIND_NO_EQUALS, kvt_pkg::CSEL_ZERO,
                                                1'b0};
                        plan_cnt = plan_cnt + 1'b1;
                        ph       = kvt_pkg::PH_DRAIN;
                    end
                end
                kvt_pkg::PH_BEFORE_VALUE: begin
                    if (status.cls.is_semi) begin
                        plan_toks[plan_cnt] = '{kvt_pkg::KIND_PAIR_END, kvt_pkg::CSEL_ZERO,
                                                plan_ovf};
                        plan_cnt   = plan_cnt + 1'b1;
                        plan_clear = 1'b1;
                        plan_ovf   = 1'b0;
                        ph         = kvt_pkg::PH_BETWEEN;
                        do_start   = 1'b1;
                    end else if (!status.cls.is_ws) begin
                        plan_toks[plan_cnt] = '{kvt_pkg::KIND_VALUE, kvt_pkg::CSEL_VALUE, 1'b0};
                        plan_cnt   = plan_cnt + 1'b1;
                        plan_clear = 1'b1;
                        ph         = kvt_pkg::PH_VALUE;
                    end
                end
                kvt_pkg::PH_VALUE: begin
                    if (status.cls.is_newline || status.cls.is_semi) begin
                        plan_toks[plan_cnt] = '{kvt_pkg::KIND_PAIR_END, kvt_pkg::CSEL_ZERO,
                                                plan_ovf};
                        plan_cnt   = plan_cnt + 1'b1;
                        plan_clear = 1'b1;
                        plan_ovf   = 1'b0;
                        ph         = kvt_pkg::PH_BETWEEN;
                        do_start   = 1'b1;
                    end else if (status.cls.is_ws) begin
                        if (status.held_full) begin
                            plan_flush     = 1'b1;
                            plan_push_late = 1'b1;
                            plan_ovf       = 1'b1;
                        end else begin
                            plan_push = 1'b1;
                        end
                    end else begin
                        plan_flush = !status.held_empty;
                        plan_toks[plan_cnt] = '{kvt_pkg::KIND_VALUE, kvt_pkg::CSEL_VALUE, 1'b0};
                        plan_cnt = plan_cnt + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (do_start && !status.cls.is_ws) begin
                if (status.cls.is_minus) begin
                    ph = kvt_pkg::PH_MINUS;
                end else begin
                    ph     = kvt_pkg::PH_KEY;
                    do_key = 1'b1;
                end
            end

            if (do_key) begin
                if (status.cls.is_ws) begin
                    ph = kvt_pkg::PH_AFTER_KEY;
                end else if (status.cls.is_equals) begin
                    ph = kvt_pkg::PH_BEFORE_VALUE;
                end else begin
                    plan_toks[plan_cnt] = '{kvt_pkg::KIND_KEY, kvt_pkg::CSEL_KEY, 1'b0};
                    plan_cnt = plan_cnt + 1'b1;
                end
            end

            do_end = s_tlast;
        end else begin
            do_end = 1'b1;
        end

        te_ph = ph;
        if (do_end) begin
            case (te_ph)
                kvt_pkg::PH_BETWEEN,
                kvt_pkg::PH_COMMENT: begin
                    plan_toks[plan_cnt] = '{kvt_pkg::KIND_TEXT_END, kvt_pkg::CSEL_ZERO, 1'b0};
                    plan_cnt = plan_cnt + 1'b1;
                end
                kvt_pkg::PH_MINUS: begin
                    plan_toks[plan_cnt] = '{kvt_pkg::KIND_KEY, kvt_pkg::CSEL_MINUS, 1'b0};
                    plan_cnt = plan_cnt + 1'b1;
                    plan_toks[plan_cnt] = '{kvt_pkg::KIND_NO_EQUALS, kvt_pkg::CSEL_ZERO, 1'b0};
                    plan_cnt = plan_cnt + 1'b1;
                end
                kvt_pkg::PH_KEY,
                kvt_pkg::PH_AFTER_KEY: begin
                    plan_toks[plan_cnt] = '{kvt_pkg::KIND_NO_EQUALS, kvt_pkg::CSEL_ZERO, 1'b0};
                    plan_cnt = plan_cnt + 1'b1;
                end
                kvt_pkg::PH_BEFORE_VALUE,
                kvt_pkg::PH_VALUE: begin
                    plan_toks[plan_cnt] = '{kvt_pkg::KIND_PAIR_END, kvt_pkg::CSEL_ZERO,
                                            plan_ovf};
                    plan_cnt = plan_cnt + 1'b1;
                    plan_toks[plan_cnt] = '{kvt_pkg::KIND_TEXT_END, kvt_pkg::CSEL_ZERO, 1'b0};
                    plan_cnt = plan_cnt + 1'b1;
                end
                default: begin
                end
            endcase
            plan_clear     = 1'b1;
            plan_push      = 1'b0;
            plan_push_late = 1'b0;
            plan_ovf       = 1'b0;
            ph = (status.cls.is_zero && !s_tlast) ? kvt_pkg::PH_DRAIN : kvt_pkg::PH_BETWEEN;
        end

        plan_phase = ph;
    end

    // next state
    always_comb begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        push_late_next = push_late_reg;
        case (seq_reg)
            kvt_pkg::SQ_IDLE: begin
                if (accept) begin
                    phase_next     = plan_phase;
                    push_late_next = plan_push_late;
                    if (plan_flush) begin
                        seq_next = kvt_pkg::SQ_FLUSH;
                    end else if (plan_cnt != '0) begin
                        seq_next = kvt_pkg::SQ_TOKENS;
                    end
                end
            end
            kvt_pkg::SQ_FLUSH: begin
                if (flush_end) begin
                    push_late_next = 1'b0;
                    seq_next = status.tok_none ? kvt_pkg::SQ_IDLE : kvt_pkg::SQ_TOKENS;
                end
            end
            kvt_pkg::SQ_TOKENS: begin
                if (status.out_free && status.tok_last) begin
                    seq_next = kvt_pkg::SQ_IDLE;
                end
            end
            default: begin
                seq_next = kvt_pkg::SQ_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready       = (seq_reg == kvt_pkg::SQ_IDLE);
        cmd            = '0;
        cmd.accept     = accept;
        cmd.toks       = plan_toks;
        cmd.tok_cnt    = plan_cnt;
        cmd.ovf_next   = plan_ovf;
        cmd.hold_push  = (accept && plan_push) || (flush_end && push_late_reg);
        cmd.hold_clear = (accept && plan_clear && !plan_flush) || flush_end;
        cmd.flush_adv  = (seq_reg == kvt_pkg::SQ_FLUSH) && status.out_free;
        cmd.tok_adv    = (seq_reg == kvt_pkg::SQ_TOKENS) && status.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg       <= kvt_pkg::SQ_IDLE;
            phase_reg     <= kvt_pkg::PH_BETWEEN;
            push_late_reg <= 1'b0;
        end else begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            push_late_reg <= push_late_next;
        end
    end

endmodule
